// ===== rtl/mdclip_pkg.sv =====
// ----------------------------------------------------------------------------
// mdclip_pkg
// Shared constants and controller/datapath interface types for the
// midpoint-subdivision line clipper.
// ----------------------------------------------------------------------------
package mdclip_pkg;

    // Coordinate format: signed fixed point, Q12.4 by default
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 4;

    // Threshold register width and the root width of its largest square
    localparam int DIST_WIDTH  = 16;
    localparam int ROOT_WIDTH  = DIST_WIDTH / 2;

    // Bisection step bound per endpoint
    localparam int STEP_MAX    = COORD_WIDTH + 1;
    localparam int STEP_WIDTH  = $clog2(STEP_MAX);

    // Configuration port
    localparam int CFG_IDX_WIDTH = 3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_BOTTOM = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_STOP_DIST_SQ  = 3'd4;

    // Coordinate written for every endpoint of a rejected segment: minus one
    localparam logic signed [COORD_WIDTH-1:0] REJECT_COORD =
        COORD_WIDTH'(-(2 ** FRAC_BITS));

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input segment
        logic classify;  // latch the trivial reject decision
        logic init;      // set up working points for a bisection pass
        logic phase_b;   // with init: pass moves the finish endpoint
        logic calc;      // register squared distance terms and midpoint
        logic step;      // apply one bisection step
        logic wrback;    // write the moved working point back to its endpoint
        logic out_load;  // load the result register
    } mdclip_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_out;   // start endpoint lies outside the window
        logic finish_out;  // finish endpoint lies outside the window
        logic reject;      // outcodes share a bit
        logic far;         // working points still at or beyond threshold
    } mdclip_sts_t;

endpackage

// ===== rtl/midpoint_subdivision_line_clip_top.sv =====
// Midpoint-subdivision line clipper. One segment in, one result out, on
// valid/ready channels; the window and stop threshold sit in a write-only
// configuration port that is always ready. A segment that passes or is
// rejected outright goes from classification straight to the output
// register. Each endpoint outside the window adds one bisection pass: each
// step registers the distance and midpoint, then compares and moves, and a
// pass ends with a final distance check and a write-back. At the bound of 17
// steps the pass ends without the final check. When the finish pass follows
// the start pass it has its own set-up state (S_INITB). The one shared
// bisection unit limits the throughput: segments are processed one at a
// time, and the next one is accepted as soon as the previous result is
// parked in the output register. A result that the receiver does not take
// holds the block and stalls the input.
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clip_top
// Top level: joins the sequencer and datapath to the external channels.
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_clip_top
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mdclip_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
    input  logic [mdclip_pkg::DIST_WIDTH-1:0]           cfg_data,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   start_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   start_y,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   finish_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   finish_y,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_start_x,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_start_y,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_finish_x,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_finish_y,
    output logic                                        rejected
);
    import mdclip_pkg::*;

    mdclip_cmd_t cmd;
    mdclip_sts_t sts;

    // Configuration writes never stall
    assign cfg_ready = 1'b1;

    mdclip_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mdclip_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start_x          (start_x),
        .start_y          (start_y),
        .finish_x         (finish_x),
        .finish_y         (finish_y),
        .cmd              (cmd),
        .sts              (sts),
        .clipped_start_x  (clipped_start_x),
        .clipped_start_y  (clipped_start_y),
        .clipped_finish_x (clipped_finish_x),
        .clipped_finish_y (clipped_finish_y),
        .rejected         (rejected)
    );

endmodule

// ===== rtl/mdclip_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdclip_ctrl
// Sequencer for the clipper: classifies a segment, runs up to two bisection
// passes and hands the result to the output register.
// ----------------------------------------------------------------------------
module mdclip_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mdclip_pkg::mdclip_sts_t sts,
    output mdclip_pkg::mdclip_cmd_t cmd
);
    import mdclip_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CLASSIFY = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_STEP     = 3'd3;
    localparam logic [2:0] S_WRBACK   = 3'd4;
    localparam logic [2:0] S_INITB    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(STEP_MAX - 1);

    logic [2:0]            state_reg, state_next;
    logic [STEP_WIDTH-1:0] steps_reg, steps_next;
    logic                  phase_b_reg, phase_b_next;
    logic                  out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        steps_next   = steps_reg;
        phase_b_next = phase_b_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                if (sts.reject || (!sts.start_out && !sts.finish_out))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.init     = 1'b1;
                    cmd.phase_b  = !sts.start_out;
                    phase_b_next = !sts.start_out;
                    steps_next   = '0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.calc   = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.far)
                begin
                    cmd.step = 1'b1;
                    if (steps_reg == STEP_LAST)
                    begin
                        state_next = S_WRBACK;
                    end
                    else
                    begin
                        steps_next = steps_reg + 1'b1;
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    state_next = S_WRBACK;
                end
            end
            S_WRBACK:
            begin
                cmd.wrback = 1'b1;
                if (!phase_b_reg && sts.finish_out)
                    state_next = S_INITB;
                else
                    state_next = S_DONE;
            end
            S_INITB:
            begin
                cmd.init     = 1'b1;
                cmd.phase_b  = 1'b1;
                phase_b_next = 1'b1;
                steps_next   = '0;
                state_next   = S_CHECK;
            end
            S_DONE:
            begin
                // Hand over once the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the transaction completes
    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steps_reg     <= '0;
            phase_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            phase_b_reg   <= phase_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/mdclip_dp.sv =====
// ----------------------------------------------------------------------------
// mdclip_dp
// Clipper datapath: window registers, outcodes, working points, squared
// distance test, midpoint bisection and the result register.
// ----------------------------------------------------------------------------
module mdclip_dp
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    input  logic [mdclip_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
    input  logic [mdclip_pkg::DIST_WIDTH-1:0]           cfg_data,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   start_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   start_y,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   finish_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   finish_y,
    input  mdclip_pkg::mdclip_cmd_t                     cmd,
    output mdclip_pkg::mdclip_sts_t                     sts,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_start_x,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_start_y,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_finish_x,
    output logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_finish_y,
    output logic                                        rejected
);
    import mdclip_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Outcode bit positions
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_BOTTOM = 2;
    localparam int BIT_TOP    = 3;

    function automatic logic [3:0] outcode(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] l,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] r,
        input logic signed [CW-1:0] t
    );
        logic [3:0] c;
        c = '0;
        if (x < l)
            c[BIT_LEFT] = 1'b1;
        else if (x > r)
            c[BIT_RIGHT] = 1'b1;
        if (y < b)
            c[BIT_BOTTOM] = 1'b1;
        else if (y > t)
            c[BIT_TOP] = 1'b1;
        return c;
    endfunction

    // Window and threshold registers
    logic signed [CW-1:0]   win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;
    logic [DIST_WIDTH-1:0]  stop_dist_reg;

    // Segment endpoints and working points
    logic signed [CW-1:0]   s_x_reg, s_y_reg, f_x_reg, f_y_reg;
    logic signed [CW-1:0]   a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic signed [CW-1:0]   m_x_reg, m_y_reg;
    logic [3:0]             code_reg;
    logic                   move_a_reg;
    logic [DIST_WIDTH-1:0]  sq_x_reg, sq_y_reg;
    logic                   big_reg;
    logic                   rej_reg;

    // Result register
    logic signed [CW-1:0]   o_sx_reg, o_sy_reg, o_fx_reg, o_fy_reg;
    logic                   o_rej_reg;

    logic [3:0]             code_s, code_f, code_m;
    logic signed [CW:0]     d_x, d_y, sum_x, sum_y;
    logic [CW:0]            abs_x, abs_y;
    logic [DIST_WIDTH:0]    dist_sum;
    logic                   outside;

    // Take configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_bottom_reg <= '0;
            win_right_reg  <= CW'(32767);
            win_top_reg    <= CW'(32767);
            stop_dist_reg  <= DIST_WIDTH'(3);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEFT:   win_left_reg   <= CW'(cfg_data);
                REG_WINDOW_BOTTOM: win_bottom_reg <= CW'(cfg_data);
                REG_WINDOW_RIGHT:  win_right_reg  <= CW'(cfg_data);
                REG_WINDOW_TOP:    win_top_reg    <= CW'(cfg_data);
                REG_STOP_DIST_SQ:  stop_dist_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Outcodes of both endpoints and of the registered midpoint
    assign code_s = outcode(s_x_reg, s_y_reg, win_left_reg, win_bottom_reg,
                            win_right_reg, win_top_reg);
    assign code_f = outcode(f_x_reg, f_y_reg, win_left_reg, win_bottom_reg,
                            win_right_reg, win_top_reg);
    assign code_m = outcode(m_x_reg, m_y_reg, win_left_reg, win_bottom_reg,
                            win_right_reg, win_top_reg);

    // Differences, magnitudes and midpoint sums of the working points
    assign d_x   = {b_x_reg[CW-1], b_x_reg} - {a_x_reg[CW-1], a_x_reg};
    assign d_y   = {b_y_reg[CW-1], b_y_reg} - {a_y_reg[CW-1], a_y_reg};
    assign abs_x = d_x[CW] ? (CW+1)'(-d_x) : (CW+1)'(d_x);
    assign abs_y = d_y[CW] ? (CW+1)'(-d_y) : (CW+1)'(d_y);
    assign sum_x = {a_x_reg[CW-1], a_x_reg} + {b_x_reg[CW-1], b_x_reg};
    assign sum_y = {a_y_reg[CW-1], a_y_reg} + {b_y_reg[CW-1], b_y_reg};

    // Distance test from the registered squares
    assign dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign outside  = |(code_m & code_reg);

    assign sts.start_out  = |code_s;
    assign sts.finish_out = |code_f;
    assign sts.reject     = |(code_s & code_f);
    assign sts.far        = big_reg || (dist_sum >= {1'b0, stop_dist_reg});

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_x_reg <= start_x;
            s_y_reg <= start_y;
            f_x_reg <= finish_x;
            f_y_reg <= finish_y;
        end
        if (cmd.classify)
        begin
            rej_reg <= sts.reject;
        end
        if (cmd.init)
        begin
            a_x_reg    <= s_x_reg;
            a_y_reg    <= s_y_reg;
            b_x_reg    <= f_x_reg;
            b_y_reg    <= f_y_reg;
            code_reg   <= cmd.phase_b ? code_f : code_s;
            move_a_reg <= !cmd.phase_b;
        end
        // Register squared distance terms and the floored midpoint
        if (cmd.calc)
        begin
            big_reg  <= (|abs_x[CW:ROOT_WIDTH]) || (|abs_y[CW:ROOT_WIDTH]);
            sq_x_reg <= abs_x[ROOT_WIDTH-1:0] * abs_x[ROOT_WIDTH-1:0];
            sq_y_reg <= abs_y[ROOT_WIDTH-1:0] * abs_y[ROOT_WIDTH-1:0];
            m_x_reg  <= sum_x[CW:1];
            m_y_reg  <= sum_y[CW:1];
        end
        // Advance the outside end or the inside end to the midpoint
        if (cmd.step)
        begin
            if (outside == move_a_reg)
            begin
                a_x_reg <= m_x_reg;
                a_y_reg <= m_y_reg;
            end
            else
            begin
                b_x_reg <= m_x_reg;
                b_y_reg <= m_y_reg;
            end
            if (outside)
                code_reg <= code_m;
        end
        if (cmd.wrback)
        begin
            if (move_a_reg)
            begin
                s_x_reg <= a_x_reg;
                s_y_reg <= a_y_reg;
            end
            else
            begin
                f_x_reg <= b_x_reg;
                f_y_reg <= b_y_reg;
            end
        end
        if (cmd.out_load)
        begin
            o_sx_reg  <= rej_reg ? REJECT_COORD : s_x_reg;
            o_sy_reg  <= rej_reg ? REJECT_COORD : s_y_reg;
            o_fx_reg  <= rej_reg ? REJECT_COORD : f_x_reg;
            o_fy_reg  <= rej_reg ? REJECT_COORD : f_y_reg;
            o_rej_reg <= rej_reg;
        end
    end

    assign clipped_start_x  = o_sx_reg;
    assign clipped_start_y  = o_sy_reg;
    assign clipped_finish_x = o_fx_reg;
    assign clipped_finish_y = o_fy_reg;
    assign rejected         = o_rej_reg;

endmodule

// ===== rtl/mdclip_chk.sv =====
// ----------------------------------------------------------------------------
// mdclip_chk
// Port-level checks for the clipper, bound to the top level.
// ----------------------------------------------------------------------------
module mdclip_chk
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic                                        in_ready,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   start_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   start_y,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   finish_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   finish_y,
    input  logic                                        out_valid,
    input  logic                                        out_ready,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_start_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_start_y,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_finish_x,
    input  logic signed [mdclip_pkg::COORD_WIDTH-1:0]   clipped_finish_y,
    input  logic                                        rejected
);
    import mdclip_pkg::*;

    // A waiting segment holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(start_x) && $stable(start_y)
            && $stable(finish_x) && $stable(finish_y))
        else $error("segment changed while waiting");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(clipped_start_x)
            && $stable(clipped_start_y) && $stable(clipped_finish_x)
            && $stable(clipped_finish_y) && $stable(rejected))
        else $error("result changed while stalled");

    // One segment at a time: no new transaction right after one is taken
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("segment accepted while another is in flight");

    // A result never appears in the cycle after a segment is taken
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early after acceptance");

    // A rejected segment carries minus one on every coordinate
    a_reject_coords: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> clipped_start_x == REJECT_COORD
            && clipped_start_y == REJECT_COORD
            && clipped_finish_x == REJECT_COORD
            && clipped_finish_y == REJECT_COORD)
        else $error("rejected result with wrong coordinates");

endmodule

bind midpoint_subdivision_line_clip_top mdclip_chk u_mdclip_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the midpoint-subdivision line clipper. The bench
// drives segments through the valid/ready input, the window and threshold
// registers through the configuration port, and random idle and stall bursts on both
// sides. Each accepted segment is clipped by a predictor in the bench, and
// each result transaction is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

    import mdclip_pkg::*;

    // Outcode bits
    localparam logic [3:0] CODE_LEFT   = 4'b0001;
    localparam logic [3:0] CODE_RIGHT  = 4'b0010;
    localparam logic [3:0] CODE_BOTTOM = 4'b0100;
    localparam logic [3:0] CODE_TOP    = 4'b1000;

    // Register index with no register behind it
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd7;

    localparam int COORD_MIN = -(2 ** (COORD_WIDTH - 1));
    localparam int COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] fx;
        logic signed [COORD_WIDTH-1:0] fy;
    } segment_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] fx;
        logic signed [COORD_WIDTH-1:0] fy;
        logic                          rej;
    } clip_result_t;

    typedef struct packed {
        int ax;
        int ay;
        int bx;
        int by;
    } span_t;

    typedef struct packed {
        logic [CFG_IDX_WIDTH-1:0] idx;
        logic [DIST_WIDTH-1:0]    data;
    } reg_write_t;

    // Clock, reset and block ports
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]      cfg_index = '0;
    logic [DIST_WIDTH-1:0]         cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [COORD_WIDTH-1:0] start_x   = '0;
    logic signed [COORD_WIDTH-1:0] start_y   = '0;
    logic signed [COORD_WIDTH-1:0] finish_x  = '0;
    logic signed [COORD_WIDTH-1:0] finish_y  = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [COORD_WIDTH-1:0] clipped_start_x;
    logic signed [COORD_WIDTH-1:0] clipped_start_y;
    logic signed [COORD_WIDTH-1:0] clipped_finish_x;
    logic signed [COORD_WIDTH-1:0] clipped_finish_y;
    logic                          rejected;

    // Window held by the predictor, tracking register writes
    int win_left   = 0;
    int win_bottom = 0;
    int win_right  = 32767;
    int win_top    = 32767;
    int stop_sq    = 3;

    // Queues fill at the front and drain from the back
    segment_t     pending_segments[$];
    clip_result_t expected_clips[$];
    reg_write_t   reg_writes[$];

    int idle_pct     = 30;
    bit quiet        = 1'b0;
    int errors       = 0;
    int results_seen = 0;

    midpoint_subdivision_line_clip_top i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_x          (start_x),
        .start_y          (start_y),
        .finish_x         (finish_x),
        .finish_y         (finish_y),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .clipped_start_x  (clipped_start_x),
        .clipped_start_y  (clipped_start_y),
        .clipped_finish_x (clipped_finish_x),
        .clipped_finish_y (clipped_finish_y),
        .rejected         (rejected)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Strict compares, left before right and bottom before top
    function automatic logic [3:0] region_code(int x, int y);
        logic [3:0] c;
        c = '0;
        if (x < win_left)
            c |= CODE_LEFT;
        else if (x > win_right)
            c |= CODE_RIGHT;
        if (y < win_bottom)
            c |= CODE_BOTTOM;
        else if (y > win_top)
            c |= CODE_TOP;
        return c;
    endfunction

    // Large deltas are far whatever the threshold
    function automatic bit far_apart(int ax, int ay, int bx, int by);
        int dx;
        int dy;
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = (by > ay) ? by - ay : ay - by;
        if (dx >= 256 || dy >= 256)
            return 1'b1;
        return (dx * dx + dy * dy) >= stop_sq;
    endfunction

    // Move the a end (move_a) or the b end toward the window by halving
    function automatic span_t bisect_toward(int ax_in, int ay_in, int bx_in, int by_in,
                                            logic [3:0] code_in, bit move_a);
        int         ax;
        int         ay;
        int         bx;
        int         by;
        int         mx;
        int         my;
        int         steps;
        logic [3:0] code;
        logic [3:0] mc;
        bit         outside;
        span_t      s;
        ax = ax_in;
        ay = ay_in;
        bx = bx_in;
        by = by_in;
        code = code_in;
        steps = 0;
        while (steps < STEP_MAX && far_apart(ax, ay, bx, by))
        begin
            mx = (ax + bx) >>> 1;
            my = (ay + by) >>> 1;
            mc = region_code(mx, my);
            outside = (mc & code) != '0;
            if (outside == move_a)
            begin
                ax = mx;
                ay = my;
            end
            else
            begin
                bx = mx;
                by = my;
            end
            if (outside)
                code = mc;
            steps++;
        end
        s.ax = ax;
        s.ay = ay;
        s.bx = bx;
        s.by = by;
        return s;
    endfunction

    function automatic clip_result_t clip_segment(int sx_in, int sy_in, int fx_in, int fy_in);
        int           sx;
        int           sy;
        int           fx;
        int           fy;
        logic [3:0]   c1;
        logic [3:0]   c2;
        span_t        sp;
        clip_result_t r;
        sx = sx_in;
        sy = sy_in;
        fx = fx_in;
        fy = fy_in;
        c1 = region_code(sx, sy);
        c2 = region_code(fx, fy);
        if ((c1 & c2) != '0)
        begin
            r.sx  = REJECT_COORD;
            r.sy  = REJECT_COORD;
            r.fx  = REJECT_COORD;
            r.fy  = REJECT_COORD;
            r.rej = 1'b1;
            return r;
        end
        // Clip the start first, then the finish along the clipped segment
        if (c1 != '0)
        begin
            sp = bisect_toward(sx, sy, fx, fy, c1, 1'b1);
            sx = sp.ax;
            sy = sp.ay;
        end
        if (c2 != '0)
        begin
            sp = bisect_toward(sx, sy, fx, fy, c2, 1'b0);
            fx = sp.bx;
            fy = sp.by;
        end
        r.sx  = sx[COORD_WIDTH-1:0];
        r.sy  = sy[COORD_WIDTH-1:0];
        r.fx  = fx[COORD_WIDTH-1:0];
        r.fy  = fy[COORD_WIDTH-1:0];
        r.rej = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int clamp16(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Mostly near the window, sometimes on its edges, sometimes anywhere
    function automatic int pick_coord(int lo, int hi);
        int a;
        int b;
        int reach;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        reach = (b - a) / 2 + 64;
        case ($urandom_range(9)) inside
            0, 1:    return int'($signed(16'($urandom)));
            2:       return clamp16(a - 1 + int'($urandom_range(2)));
            3:       return clamp16(b - 1 + int'($urandom_range(2)));
            4, 5:    return rand_between(a, b);
            default: return clamp16(rand_between(a - reach, b + reach));
        endcase
    endfunction

    task automatic push_segment(int sx, int sy, int fx, int fy);
        segment_t seg;
        seg.sx = sx[COORD_WIDTH-1:0];
        seg.sy = sy[COORD_WIDTH-1:0];
        seg.fx = fx[COORD_WIDTH-1:0];
        seg.fy = fy[COORD_WIDTH-1:0];
        pending_segments.push_front(seg);
    endtask

    task automatic push_write(logic [CFG_IDX_WIDTH-1:0] idx, int value);
        reg_write_t w;
        w.idx  = idx;
        w.data = value[DIST_WIDTH-1:0];
        reg_writes.push_front(w);
    endtask

    // Hold until every write, segment and result has gone through
    task automatic wait_drained();
        do
            @(negedge clk);
        while (reg_writes.size() != 0 || cfg_valid || pending_segments.size() != 0 ||
               in_valid || expected_clips.size() != 0);
    endtask

    task automatic run_phase(int l, int b, int r, int t, int stop, int count, int pct);
        push_write(REG_WINDOW_LEFT, l);
        push_write(REG_WINDOW_BOTTOM, b);
        push_write(REG_WINDOW_RIGHT, r);
        push_write(REG_WINDOW_TOP, t);
        push_write(REG_STOP_DIST_SQ, stop);
        wait_drained();
        idle_pct <= pct;
        repeat (count)
            push_segment(pick_coord(l, r), pick_coord(b, t), pick_coord(l, r), pick_coord(b, t));
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever
            #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Configuration writer: one write per transaction, predictor tracks it
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : cfg_writer
        reg_write_t w;
        logic       nxt_valid;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_valid = cfg_valid;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WINDOW_LEFT:   win_left   = int'($signed(cfg_data));
                    REG_WINDOW_BOTTOM: win_bottom = int'($signed(cfg_data));
                    REG_WINDOW_RIGHT:  win_right  = int'($signed(cfg_data));
                    REG_WINDOW_TOP:    win_top    = int'($signed(cfg_data));
                    REG_STOP_DIST_SQ:  stop_sq    = int'(cfg_data);
                    default:           ;
                endcase
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && reg_writes.size() != 0)
            begin
                w = reg_writes.pop_back();
                cfg_index <= w.idx;
                cfg_data  <= w.data;
                nxt_valid = 1'b1;
            end
            cfg_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Segment driver: predict on acceptance, then offer the next segment
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : segment_driver
        segment_t seg;
        logic     nxt_valid;
        int       gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                expected_clips.push_front(clip_segment(start_x, start_y, finish_x, finish_y));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_segments.size() != 0)
                begin
                    if (!quiet && int'($urandom_range(99)) < idle_pct)
                        gap_left = $urandom_range(9);
                    else
                    begin
                        seg = pending_segments.pop_back();
                        start_x  <= seg.sx;
                        start_y  <= seg.sy;
                        finish_x <= seg.fx;
                        finish_y <= seg.fy;
                        nxt_valid = 1'b1;
                    end
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each transaction, stall the receiver at random
    // ------------------------------------------------------------------------
    task automatic compare_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        clip_result_t want;
        logic         nxt_ready;
        int           stall_left;
        bit           long_hold_done;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_clips.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0d %0d",
                             $time, clipped_start_x, clipped_start_y, clipped_finish_x,
                             clipped_finish_y, rejected);
                    errors++;
                end
                else
                begin
                    want = expected_clips.pop_back();
                    compare_field("clipped_start_x", want.sx, clipped_start_x);
                    compare_field("clipped_start_y", want.sy, clipped_start_y);
                    compare_field("clipped_finish_x", want.fx, clipped_finish_x);
                    compare_field("clipped_finish_y", want.fy, clipped_finish_y);
                    compare_field("rejected", want.rej, rejected);
                end
                results_seen++;
            end
            // Hold off once for a long stretch so the input backs up
            if (results_seen == 250 && !long_hold_done)
            begin
                stall_left = 400;
                long_hold_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (!quiet && int'($urandom_range(99)) < idle_pct)
            begin
                stall_left = $urandom_range(9);
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            out_ready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        int l;
        int b;
        int r;
        int t;
        int stop;
        int swap;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: 0..32767 on both axes, threshold 3
        push_segment(16, 16, 1600, 1600);                       // both inside
        push_segment(0, 0, 32767, 32767);                       // on the edges
        push_segment(-1, 100, 500, 500);                        // start just left
        push_segment(100, 100, 200, -1);                        // finish just below
        push_segment(-32768, 100, 500, 500);                    // start far left
        push_segment(100, 100, 200, -32768);                    // finish far below
        push_segment(-1000, 500, 500, -1000);                   // both outside, crossing
        push_segment(-32768, -32768, 32767, 32767);             // corner to corner
        push_segment(32767, 32767, -32768, -32768);             // reversed
        push_segment(-5, 10, -100, 20);                         // reject on left
        push_segment(10, -1, 20, -32768);                       // reject below
        push_segment(-1, -1, -1, -1);                           // reject, single point
        push_segment(-32768, -32768, -32768, -32768);           // most negative
        push_segment(32767, 32767, 32767, 32767);               // most positive
        push_segment(-32768, 32767, 32767, -32768);             // opposite corners
        push_segment(-16, 5000, 5000, -16);                     // both outside, near
        push_segment(0, -32768, 0, 32767);                      // vertical through edge
        push_segment(-32768, 0, 32767, 0);                      // horizontal along edge
        push_segment(12345, 23456, 3456, 7890);                 // plain inside
        push_segment(-300, 40, 2, 1);                           // short clip
        wait_drained();

        // Unused register index must change nothing
        push_write(REG_SPARE, 16'h8000);
        run_phase(-1600, -800, 1600, 800, 3, 200, 30);

        // Widest window and largest threshold, no idling
        run_phase(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 65535, 150, 0);

        // Inverted window on both axes
        run_phase(200, 100, -200, -100, 3, 150, 40);

        // Window shrunk to a single point
        run_phase(0, 0, 0, 0, 3, 150, 20);

        // Random windows and thresholds
        repeat (4)
        begin
            l = rand_between(-30000, 20000);
            r = clamp16(l + rand_between(16, 12000));
            b = rand_between(-30000, 20000);
            t = clamp16(b + rand_between(16, 12000));
            if ($urandom_range(3) == 0)
            begin
                swap = l;
                l = r;
                r = swap;
            end
            case ($urandom_range(2))
                0:       stop = 3;
                1:       stop = rand_between(3, 64);
                default: stop = rand_between(3, 65535);
            endcase
            run_phase(l, b, r, t, stop, 150, rand_between(0, 50));
        end

        // Final stretch at full rate
        quiet <= 1'b1;
        run_phase(-4000, -3000, 6000, 2500, 7, 150, 0);

        repeat (100) @(posedge clk);
        if (errors == 0 && expected_clips.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Time limit
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== midpoint_subdivision_line_clip_top.f =====
rtl/mdclip_pkg.sv
rtl/mdclip_ctrl.sv
rtl/mdclip_dp.sv
rtl/midpoint_subdivision_line_clip_top.sv
rtl/mdclip_chk.sv
tb/tb.sv
